// File: sv/text_console_glyph_renderer_assert.svh
// Assertion macros for the port checker of the text console renderer.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

// Same-cycle implication.
`define TCGR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TCGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/tcgr_pkg.sv
// Shared constants, codes and structs of the text console glyph renderer.
// No dependencies; imported by every module of the block but tcgr_ram.
package tcgr_pkg;

   // console geometry (COLUMNS must be a power of two)
   localparam int COLUMNS      = 128;
   localparam int ROWS         = 48;
   localparam int GLYPH_HEIGHT = 16;
   localparam int GLYPH_COUNT  = 256;

   localparam int COL_W    = $clog2(COLUMNS);
   localparam int ROW_W    = $clog2(ROWS);
   localparam int J_W      = $clog2(GLYPH_HEIGHT);
   localparam int K_W      = $clog2(ROWS + 1);
   localparam int FONT_DEPTH = GLYPH_COUNT * 16;
   localparam int FONT_AW  = $clog2(FONT_DEPTH);

   localparam int PIX_W    = 10;
   localparam int OFS_W    = 14;
   localparam int CELL_W   = OFS_W - 1;
   localparam int COLOR_W  = 32;
   localparam int REQ_W    = 128;
   localparam int RSP_W    = 112;
   localparam int USER_W   = 3;

   // commands
   localparam logic [2:0] CMD_PRINT  = 3'd0;
   localparam logic [2:0] CMD_ERASE  = 3'd1;
   localparam logic [2:0] CMD_DRAW   = 3'd2;
   localparam logic [2:0] CMD_OFFSET = 3'd3;
   localparam logic [2:0] CMD_HIDDEN = 3'd4;
   localparam logic [2:0] CMD_CLEAR  = 3'd5;
   localparam logic [2:0] CMD_LOAD   = 3'd6;

   // result kinds
   localparam logic [2:0] KIND_GLYPH  = 3'd0;
   localparam logic [2:0] KIND_MASK   = 3'd1;
   localparam logic [2:0] KIND_SCROLL = 3'd2;
   localparam logic [2:0] KIND_CLEAR  = 3'd3;
   localparam logic [2:0] KIND_NONE   = 3'd4;

   // control characters
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] CH_SPACE     = 8'd32;

   // register indexes
   localparam logic REG_CARET_COLOR  = 1'b0;
   localparam logic REG_SCROLL_LINES = 1'b1;

   localparam logic [COLOR_W-1:0] CARET_COLOR_RESET  = 32'h00FF003C;
   localparam logic [5:0]         SCROLL_LINES_RESET = 6'd5;

   localparam logic [7:0] BOX_EDGE = 8'hFF;
   localparam logic [7:0] BOX_SIDE = 8'h81;

   // request payload, last field in the low bits
   typedef struct packed {
      logic [5:0]         pad;
      logic [7:0]         font_bits;
      logic [11:0]        font_address;
      logic               hide_cursor;
      logic [OFS_W-1:0]   cursor_offset;
      logic [COLOR_W-1:0] glyph_bg;
      logic [COLOR_W-1:0] fg_color;
      logic [5:0]         y_override;
      logic               y_valid;
      logic [6:0]         x_override;
      logic               x_valid;
      logic [7:0]         char_code;
   } req_data_type;

   // response payload, last field in the low bits
   typedef struct packed {
      logic [5:0]         pad;
      logic [OFS_W-1:0]   offset_now;
      logic [COLOR_W-1:0] back_color;
      logic [COLOR_W-1:0] paint_color;
      logic [7:0]         row_bits;
      logic [PIX_W-1:0]   pixel_y;
      logic [PIX_W-1:0]   pixel_x;
   } rsp_data_type;

   typedef enum logic [1:0] {SEG_NONE, SEG_BOX, SEG_GLYPH} seg_kind_type;
   typedef enum logic [1:0] {TAIL_NONE, TAIL_SCROLL, TAIL_CLEAR, TAIL_NODRAW} tail_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             hidden;
   } cursor_type;

   // one run of GLYPH_HEIGHT rows
   typedef struct packed {
      seg_kind_type       kind;
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic [7:0]         code;
      logic [COLOR_W-1:0] paint;
      logic [COLOR_W-1:0] back;
   } seg_type;

   // everything one command turns into
   typedef struct packed {
      seg_type          seg1;
      seg_type          seg2;
      tail_type         tail;
      logic [K_W-1:0]   k;
      cursor_type       next;
      logic [OFS_W-1:0] offset;
      logic             font_we;
   } plan_type;

   // one result on its way to the output
   typedef struct packed {
      logic [2:0]         kind;
      logic [PIX_W-1:0]   px;
      logic [PIX_W-1:0]   py;
      logic               use_ram;
      logic [7:0]         bits;
      logic [COLOR_W-1:0] paint;
      logic [COLOR_W-1:0] back;
      logic [OFS_W-1:0]   offset;
      logic               last;
   } issue_type;

endpackage

// File: sv/tcgr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tcgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: sv/tcgr_plan.sv
// Command decode: turns one request and the cursor into a plan of row runs,
// a closing operation and the new cursor. Depends on tcgr_pkg.
module tcgr_plan (
   input  logic [2:0]                   command,
   input  tcgr_pkg::req_data_type       req,
   input  tcgr_pkg::cursor_type         cur,
   input  logic [tcgr_pkg::COLOR_W-1:0] caret_color,
   input  logic [5:0]                   scroll_lines,
   output tcgr_pkg::plan_type           plan
);
   import tcgr_pkg::*;

   logic [COL_W-1:0]   col0, col_bs, cell_col;
   logic [ROW_W-1:0]   row0, cell_row;
   logic [COL_W:0]     col1;
   logic [ROW_W:0]     row1;
   logic [K_W-1:0]     k;
   logic [CELL_W-1:0]  slot, slot_hi;
   logic [7:0]         code_mod;
   logic [COLOR_W-1:0] draw_paint;
   seg_type            box_cur;
   plan_type           p;

   always_comb begin
      col0 = req.x_valid ?
             ((int'(req.x_override) > COLUMNS - 1) ? COL_W'(COLUMNS - 1)
                                                   : COL_W'(req.x_override))
             : cur.col;
      row0 = req.y_valid ?
             ((int'(req.y_override) > ROWS - 1) ? ROW_W'(ROWS - 1)
                                                : ROW_W'(req.y_override))
             : cur.row;
      col_bs = (col0 != '0) ? col0 - 1'b1 : '0;
      code_mod = (int'(req.char_code) >= GLYPH_COUNT) ?
                 8'(int'(req.char_code) - GLYPH_COUNT) : req.char_code;

      // zero acts as one, more than the screen acts as the screen
      if (scroll_lines == '0) begin
         k = K_W'(1);
      end else if (int'(scroll_lines) > ROWS) begin
         k = K_W'(ROWS);
      end else begin
         k = K_W'(scroll_lines);
      end

      slot     = req.cursor_offset[OFS_W-1:1];
      slot_hi  = slot >> COL_W;
      cell_col = slot[COL_W-1:0];
      cell_row = (int'(slot_hi) > ROWS - 1) ? ROW_W'(ROWS - 1) : ROW_W'(slot_hi);

      draw_paint = cur.hidden ? '0 : caret_color;

      box_cur       = '0;
      box_cur.kind  = SEG_BOX;
      box_cur.col   = cur.col;
      box_cur.row   = cur.row;

      col1 = '0;
      row1 = '0;

      p        = '0;
      p.seg1.kind = SEG_NONE;
      p.seg2.kind = SEG_NONE;
      p.tail   = TAIL_NONE;
      p.k      = k;
      p.next   = cur;

      case (command)
         CMD_PRINT: begin
            col1 = {1'b0, col0};
            row1 = {1'b0, row0};
            case (req.char_code)
               CH_NEWLINE: begin
                  col1 = '0;
                  row1 = row1 + 1'b1;
               end
               CH_RETURN: begin
                  col1 = '0;
               end
               CH_BACKSPACE: begin
                  // erase box, step back, paint a space there
                  p.seg1.kind = SEG_BOX;
                  p.seg1.col  = col0;
                  p.seg1.row  = row0;
                  p.seg2.kind = SEG_GLYPH;
                  p.seg2.col  = col_bs;
                  p.seg2.row  = row0;
                  p.seg2.code = CH_SPACE;
                  p.seg2.paint = req.fg_color;
                  p.seg2.back  = req.glyph_bg;
                  col1 = {1'b0, col_bs};
               end
               default: begin
                  p.seg1.kind  = SEG_GLYPH;
                  p.seg1.col   = col0;
                  p.seg1.row   = row0;
                  p.seg1.code  = code_mod;
                  p.seg1.paint = req.fg_color;
                  p.seg1.back  = req.glyph_bg;
                  col1 = col1 + 1'b1;
               end
            endcase
            // wrap past the last column
            if (int'(col1) >= COLUMNS) begin
               col1 = '0;
               row1 = row1 + 1'b1;
            end
            // scroll past the last row
            if (int'(row1) >= ROWS) begin
               p.tail = TAIL_SCROLL;
               row1 = (row1 >= (ROW_W+1)'(k)) ? row1 - (ROW_W+1)'(k) : '0;
               if (int'(row1) > ROWS - 1) begin
                  row1 = (ROW_W+1)'(ROWS - 1);
               end
               col1 = '0;
            end
            p.next.col = COL_W'(col1);
            p.next.row = ROW_W'(row1);
         end
         CMD_ERASE: begin
            p.seg1 = box_cur;
         end
         CMD_DRAW: begin
            p.seg1       = box_cur;
            p.seg1.paint = draw_paint;
         end
         CMD_OFFSET: begin
            p.seg1       = box_cur;
            p.seg2.kind  = SEG_BOX;
            p.seg2.col   = cell_col;
            p.seg2.row   = cell_row;
            p.seg2.paint = draw_paint;
            p.next.col   = cell_col;
            p.next.row   = cell_row;
         end
         CMD_HIDDEN: begin
            p.next.hidden = req.hide_cursor;
            p.seg1        = box_cur;
            p.seg1.paint  = req.hide_cursor ? '0 : caret_color;
         end
         CMD_CLEAR: begin
            p.next.col = '0;
            p.next.row = '0;
            p.tail     = TAIL_CLEAR;
         end
         CMD_LOAD: begin
            p.font_we = (int'(req.font_address) < FONT_DEPTH);
         end
         default: begin
            p.font_we = 1'b0;
         end
      endcase

      if (p.seg1.kind == SEG_NONE && p.tail == TAIL_NONE) begin
         p.tail = TAIL_NODRAW;
      end

      p.offset = OFS_W'((int'(p.next.row) * COLUMNS + int'(p.next.col)) * 2);
   end

   assign plan = p;
endmodule

// File: sv/tcgr_seq.sv
// Sequencer: holds the cursor and current plan, walks its row runs, issues
// a result and a font read per cycle unless stalled. Depends on tcgr_pkg.
module tcgr_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  tcgr_pkg::plan_type               plan,
   input  logic                             issue_ready,
   output logic                             idle,
   output tcgr_pkg::cursor_type             cursor,
   output logic                             issue_valid,
   output tcgr_pkg::issue_type              issue,
   output logic                             ram_re,
   output logic [tcgr_pkg::FONT_AW-1:0]     ram_raddr
);
   import tcgr_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SEG1, ST_SEG2, ST_TAIL} state_type;

   state_type        state_ff, state_in;
   logic [J_W-1:0]   j_ff, j_in;
   cursor_type       cur_ff, cur_in;
   plan_type         plan_ff, plan_in;
   seg_type          seg;
   logic             j_last, box_edge, fire;
   issue_type        iss;

   assign issue_valid = (state_ff != ST_IDLE);
   assign idle        = (state_ff == ST_IDLE);
   assign fire        = issue_valid && issue_ready;

   // result of the current step
   always_comb begin
      seg      = (state_ff == ST_SEG2) ? plan_ff.seg2 : plan_ff.seg1;
      j_last   = (j_ff == J_W'(GLYPH_HEIGHT - 1));
      box_edge = (j_ff == '0) || j_last;
      iss        = '0;
      iss.offset = plan_ff.offset;
      case (state_ff)
         ST_SEG1, ST_SEG2: begin
            iss.kind    = (seg.kind == SEG_GLYPH) ? KIND_GLYPH : KIND_MASK;
            iss.px      = PIX_W'(int'(seg.col) * 8);
            iss.py      = PIX_W'(int'(seg.row) * GLYPH_HEIGHT + int'(j_ff));
            iss.use_ram = (seg.kind == SEG_GLYPH);
            iss.bits    = box_edge ? BOX_EDGE : BOX_SIDE;
            iss.paint   = seg.paint;
            iss.back    = seg.back;
            iss.last    = j_last && (plan_ff.tail == TAIL_NONE) &&
                          ((state_ff == ST_SEG2) || (plan_ff.seg2.kind == SEG_NONE));
         end
         ST_TAIL: begin
            iss.last = 1'b1;
            case (plan_ff.tail)
               TAIL_SCROLL: begin
                  iss.kind = KIND_SCROLL;
                  iss.py   = PIX_W'(int'(plan_ff.k) * GLYPH_HEIGHT);
                  iss.bits = 8'(plan_ff.k);
               end
               TAIL_CLEAR: iss.kind = KIND_CLEAR;
               default:    iss.kind = KIND_NONE;
            endcase
         end
         default: iss.use_ram = 1'b0;
      endcase
   end

   assign issue     = iss;
   assign ram_re    = fire;
   assign ram_raddr = FONT_AW'(int'(seg.code) * 16 + int'(j_ff));
   assign cursor    = cur_ff;

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      cur_in   = cur_ff;
      plan_in  = plan_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               plan_in  = plan;
               cur_in   = plan.next;
               j_in     = '0;
               state_in = (plan.seg1.kind != SEG_NONE) ? ST_SEG1 : ST_TAIL;
            end
         end
         ST_SEG1: begin
            if (fire) begin
               if (j_last) begin
                  j_in = '0;
                  if (plan_ff.seg2.kind != SEG_NONE) begin
                     state_in = ST_SEG2;
                  end else if (plan_ff.tail != TAIL_NONE) begin
                     state_in = ST_TAIL;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         ST_SEG2: begin
            if (fire) begin
               if (j_last) begin
                  j_in     = '0;
                  state_in = (plan_ff.tail != TAIL_NONE) ? ST_TAIL : ST_IDLE;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         ST_TAIL: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         j_ff     <= '0;
         cur_ff   <= '0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         cur_ff   <= cur_in;
      end
   end
endmodule

// File: sv/tcgr_out.sv
// Result path: a stage aligned with the font read, then the output register
// that holds a result until the transfer completes. Depends on tcgr_pkg.
module tcgr_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   issue_valid,
   input  tcgr_pkg::issue_type    issue,
   output logic                   issue_ready,
   input  logic [7:0]             ram_rdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [2:0]             rsp_kind,
   output tcgr_pkg::rsp_data_type rsp_data,
   output logic                   rsp_last
);
   import tcgr_pkg::*;

   logic         s2_valid_ff, s2_valid_in;
   issue_type    s2_ff;
   logic         out_valid_ff, out_valid_in;
   logic [2:0]   kind_ff;
   rsp_data_type data_ff, data_in;
   logic         last_ff;
   logic         out_free, s2_move, issue_fire;

   assign out_free    = !out_valid_ff || rsp_tready;
   assign s2_move     = s2_valid_ff && out_free;
   assign issue_ready = !s2_valid_ff || out_free;
   assign issue_fire  = issue_valid && issue_ready;

   always_comb begin
      s2_valid_in = issue_fire ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
      out_valid_in = s2_move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      data_in             = '0;
      data_in.pixel_x     = s2_ff.px;
      data_in.pixel_y     = s2_ff.py;
      data_in.row_bits    = s2_ff.use_ram ? ram_rdata : s2_ff.bits;
      data_in.paint_color = s2_ff.paint;
      data_in.back_color  = s2_ff.back;
      data_in.offset_now  = s2_ff.offset;
   end

   always_ff @(posedge clock) begin
      if (issue_fire) begin
         s2_ff <= issue;
      end
      if (s2_move) begin
         kind_ff <= s2_ff.kind;
         data_ff <= data_in;
         last_ff <= s2_ff.last;
      end
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_data   = data_ff;
   assign rsp_last   = last_ff;
endmodule

// File: sv/text_console_glyph_renderer.sv
// Top level of the text console glyph renderer: ports, control registers,
// font memory. Depends on tcgr_pkg, tcgr_ram, tcgr_plan, tcgr_seq, tcgr_out.
//
// Channel | Direction | Carries
// req_    | in        | one command; tuser = command, tdata = operands
// rsp_    | out       | drawing ops; tuser = kind, tlast = last op of a command
// csr_    | in        | register writes: 0 caret color, 1 scroll_lines
//
// A command is taken when the block is idle, and its results follow one per
// cycle unless rsp_ stalls: 16 for a printed glyph, box and set hidden, 32
// for backspace and set offset, plus one for a scroll; newline, return,
// clear, load font and the rest give one. The glyph rows step through the
// single font read port one row per cycle, unless rsp_ stalls.
// Reset is synchronous and active high; the font memory is not cleared and
// must be loaded before glyphs are printed. A stalled rsp_ holds its
// transfer; the sequencer waits behind it while the next command waits.
module text_console_glyph_renderer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // char_code, x_valid, x_override, y_valid, y_override, fg_color,
   // glyph_bg, cursor_offset, hide_cursor, font_address, font_bits, pad
   input  logic [tcgr_pkg::REQ_W-1:0]    req_tdata,
   // command
   input  logic [tcgr_pkg::USER_W-1:0]   req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // pixel_x, pixel_y, row_bits, paint_color, back_color, offset_now, pad
   output logic [tcgr_pkg::RSP_W-1:0]    rsp_tdata,
   // kind
   output logic [tcgr_pkg::USER_W-1:0]   rsp_tuser,
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [tcgr_pkg::COLOR_W-1:0]  csr_data
);
   import tcgr_pkg::*;

   logic [COLOR_W-1:0] caret_color_ff, caret_color_in;
   logic [5:0]         scroll_lines_ff, scroll_lines_in;

   req_data_type       req;
   rsp_data_type       rsp_data;
   plan_type           plan;
   cursor_type         cursor;
   issue_type          issue;
   logic               idle, accept, issue_valid, issue_ready;
   logic               ram_re;
   logic [FONT_AW-1:0] ram_raddr;
   logic [7:0]         ram_rdata;

   assign req        = req_data_type'(req_tdata);
   assign req_tready = idle;
   assign accept     = req_tvalid && req_tready;

   // register writes are always taken; software writes only while idle, unchecked by the block itself
   assign csr_ready = 1'b1;

   always_comb begin
      caret_color_in  = caret_color_ff;
      scroll_lines_in = scroll_lines_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_CARET_COLOR:  caret_color_in  = csr_data;
            REG_SCROLL_LINES: scroll_lines_in = csr_data[5:0];
            default:          caret_color_in  = caret_color_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         caret_color_ff  <= CARET_COLOR_RESET;
         scroll_lines_ff <= SCROLL_LINES_RESET;
      end else begin
         caret_color_ff  <= caret_color_in;
         scroll_lines_ff <= scroll_lines_in;
      end
   end

   // decode against the cursor as it stands when the command arrives
   tcgr_plan u_plan (
      .command      (req_tuser),
      .req          (req),
      .cur          (cursor),
      .caret_color  (caret_color_ff),
      .scroll_lines (scroll_lines_ff),
      .plan         (plan)
   );

   tcgr_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .plan        (plan),
      .issue_ready (issue_ready),
      .idle        (idle),
      .cursor      (cursor),
      .issue_valid (issue_valid),
      .issue       (issue),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr)
   );

   // font rows are written on load font; all reads of a command are issued
   // before the next command can be taken, so no overlap needs forwarding
   tcgr_ram #(
      .WIDTH (8),
      .DEPTH (FONT_DEPTH)
   ) u_font (
      .clock (clock),
      .we    (accept && plan.font_we),
      .waddr (req.font_address[FONT_AW-1:0]),
      .wdata (req.font_bits),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   tcgr_out u_out (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue       (issue),
      .issue_ready (issue_ready),
      .ram_rdata   (ram_rdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_kind    (rsp_tuser),
      .rsp_data    (rsp_data),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = rsp_data;
endmodule

// File: sv/tcgr_port_check.sv
// Port-level checker of the text console glyph renderer, bound to the top.
// Depends on tcgr_pkg and text_console_glyph_renderer_assert.svh.
`include "text_console_glyph_renderer_assert.svh"

module tcgr_port_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [tcgr_pkg::RSP_W-1:0]    rsp_tdata,
   input logic [tcgr_pkg::USER_W-1:0]   rsp_tuser,
   input logic                          rsp_tlast
);
   import tcgr_pkg::*;

   rsp_data_type rsp_d;
   assign rsp_d = rsp_data_type'(rsp_tdata);

   // a taken command closes the input in the next cycle
   `TCGR_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready, "input open right after a transfer")

   // a stalled result holds
   `TCGR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // scroll, clear and no-draw always close a command
   `TCGR_ASSERT_IMPLY(a_tail_last, clock, reset, rsp_tvalid && (rsp_tuser == KIND_SCROLL || rsp_tuser == KIND_CLEAR || rsp_tuser == KIND_NONE), rsp_tlast, "closing op without tlast")

   // clear homes the cursor
   `TCGR_ASSERT_IMPLY(a_clear_home, clock, reset, rsp_tvalid && rsp_tuser == KIND_CLEAR, rsp_d.offset_now == '0 && rsp_d.pixel_y == '0, "clear left cursor away from home")

   // cursor box rows are edge or side patterns on no background
   `TCGR_ASSERT_IMPLY(a_box_shape, clock, reset, rsp_tvalid && rsp_tuser == KIND_MASK, rsp_d.back_color == '0 && (rsp_d.row_bits == BOX_EDGE || rsp_d.row_bits == BOX_SIDE), "bad cursor box row")
endmodule

bind text_console_glyph_renderer tcgr_port_check u_port_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: bench/tb_top.sv
// Self-checking bench for text_console_glyph_renderer: loads the glyphs it prints,
// runs a directed table and random command phases, and checks every drawing op
// against its own console model. Depends on tcgr_pkg and the RTL of the block.
module tb_top;
   import tcgr_pkg::*;

   // the command field is three bits wide; code 7 is a no-op
   localparam logic [2:0] CMD_NOP = 3'd7;

   // one drawing op as the block presents it on rsp_
   typedef struct packed {
      logic [2:0]  kind;
      logic [9:0]  px;
      logic [9:0]  py;
      logic [7:0]  bits;
      logic [31:0] paint;
      logic [31:0] back;
      logic [13:0] offset;
      logic        last;
   } draw_op_type;

   // directed row; want_* is used only where typed is set
   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  ch;
      logic        xv;
      logic [6:0]  x;
      logic        yv;
      logic [5:0]  y;
      logic [31:0] fg;
      logic [31:0] bg;
      logic [13:0] ofs;
      logic        hide;
      logic [11:0] addr;
      logic [7:0]  bits;
      logic        typed;
      logic [2:0]  want_kind;
      logic [13:0] want_ofs;
   } stim_row_type;

   // cmd, char, xv, x, yv, y, fg, bg, offset, hide, font addr, font bits,
   // typed, kind, offset_now
   localparam stim_row_type DIRECTED [0:21] = '{
      '{CMD_DRAW,   8'h00, 0, 7'd0,   0, 6'd0,  32'h0, 32'h0, 14'd0, 0, 12'h000, 8'h00,
        0, KIND_NONE, 14'd0},
      '{CMD_LOAD,   8'h00, 0, 7'd0,   0, 6'd0,  32'h0, 32'h0, 14'd0, 0, 12'h000, 8'h00,
        1, KIND_NONE, 14'd0},
      '{CMD_LOAD,   8'h00, 0, 7'd0,   0, 6'd0,  32'h0, 32'h0, 14'd0, 0, 12'hFFF, 8'hFF,
        1, KIND_NONE, 14'd0},
      '{CMD_PRINT,  8'h41, 0, 7'd0,   0, 6'd0,  32'hFFFFFFFF, 32'h0, 14'd0, 0, 12'h0, 8'h0,
        0, KIND_NONE, 14'd0},
      // last column: glyph then wrap to the next row
      '{CMD_PRINT,  8'hFF, 1, 7'd127, 0, 6'd0,  32'h12345678, 32'h9ABCDEF0, 14'd0, 0,
        12'h0, 8'h0, 0, KIND_NONE, 14'd0},
      // row override past the bottom clamps to the last row
      '{CMD_PRINT,  8'h00, 1, 7'd0,   1, 6'd63, 32'h0, 32'hFFFFFFFF, 14'd0, 0, 12'h0, 8'h0,
        0, KIND_NONE, 14'd0},
      // newline on the last row scrolls
      '{CMD_PRINT,  CH_NEWLINE, 0, 7'd0, 0, 6'd0, 32'h0, 32'h0, 14'd0, 0, 12'h0, 8'h0,
        0, KIND_NONE, 14'd0},
      '{CMD_PRINT,  CH_RETURN, 1, 7'd9, 0, 6'd0, 32'h0, 32'h0, 14'd0, 0, 12'h0, 8'h0,
        0, KIND_NONE, 14'd0},
      // backspace at column 0 stays there
      '{CMD_PRINT,  CH_BACKSPACE, 0, 7'd0, 0, 6'd0, 32'hA5A5A5A5, 32'h5A5A5A5A, 14'd0, 0,
        12'h0, 8'h0, 0, KIND_NONE, 14'd0},
      '{CMD_PRINT,  CH_BACKSPACE, 1, 7'd5, 0, 6'd0, 32'h00FF00FF, 32'hFF00FF00, 14'd0, 0,
        12'h0, 8'h0, 0, KIND_NONE, 14'd0},
      '{CMD_ERASE,  8'h00, 0, 7'd0,   0, 6'd0,  32'h0, 32'h0, 14'd0, 0, 12'h0, 8'h0,
        0, KIND_NONE, 14'd0},
      '{CMD_OFFSET, 8'h00, 0, 7'd0,   0, 6'd0,  32'h0, 32'h0, 14'd0, 0, 12'h0, 8'h0,
        0, KIND_NONE, 14'd0},
      // offset past the screen: row clamps
      '{CMD_OFFSET, 8'h00, 0, 7'd0,   0, 6'd0,  32'h0, 32'h0, 14'h3FFF, 0, 12'h0, 8'h0,
        0, KIND_NONE, 14'd0},
      // wrap from the last cell straight into a scroll
      '{CMD_PRINT,  8'h5A, 0, 7'd0,   0, 6'd0,  32'hCAFE0001, 32'h0, 14'd0, 0, 12'h0, 8'h0,
        0, KIND_NONE, 14'd0},
      '{CMD_OFFSET, 8'h00, 0, 7'd0,   0, 6'd0,  32'h0, 32'h0, 14'd12286, 0, 12'h0, 8'h0,
        0, KIND_NONE, 14'd0},
      '{CMD_HIDDEN, 8'h00, 0, 7'd0,   0, 6'd0,  32'h0, 32'h0, 14'd0, 1, 12'h0, 8'h0,
        0, KIND_NONE, 14'd0},
      // hidden cursor draws with color zero
      '{CMD_DRAW,   8'h00, 0, 7'd0,   0, 6'd0,  32'h0, 32'h0, 14'd0, 0, 12'h0, 8'h0,
        0, KIND_NONE, 14'd0},
      '{CMD_PRINT,  CH_NEWLINE, 0, 7'd0, 1, 6'd47, 32'h0, 32'h0, 14'd0, 0, 12'h0, 8'h0,
        0, KIND_NONE, 14'd0},
      '{CMD_HIDDEN, 8'h00, 0, 7'd0,   0, 6'd0,  32'h0, 32'h0, 14'd0, 0, 12'h0, 8'h0,
        0, KIND_NONE, 14'd0},
      '{CMD_CLEAR,  8'h00, 0, 7'd0,   0, 6'd0,  32'h0, 32'h0, 14'd0, 0, 12'h0, 8'h0,
        1, KIND_CLEAR, 14'd0},
      '{CMD_NOP,    8'h00, 0, 7'd0,   0, 6'd0,  32'h0, 32'h0, 14'd0, 0, 12'h0, 8'h0,
        1, KIND_NONE, 14'd0},
      // every operand field at its top value
      '{CMD_PRINT,  8'hFF, 1, 7'd127, 1, 6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, 14'h3FFF, 1,
        12'hFFF, 8'hFF, 0, KIND_NONE, 14'd0}
   };

   localparam logic [5:0] SCROLL_PLAN [0:3] = '{6'd0, 6'd63, 6'd1, 6'd47};

   // the only glyphs the bench prints; each is loaded before use
   localparam logic [7:0] GLYPH_SET [0:4] = '{8'h00, CH_SPACE, 8'h41, 8'h5A, 8'hFF};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic [USER_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic [USER_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = REG_CARET_COLOR;
   logic [COLOR_W-1:0]    csr_data = '0;

   // when set, neither side idles
   logic                  steady_run = 1'b0;

   // console model state; column and row are ints since the column
   // briefly reaches COLUMNS and the row ROWS before wrap and scroll
   int                    txt_col = 0;
   int                    txt_row = 0;
   logic                  txt_hidden = 1'b0;
   logic [31:0]           box_color = CARET_COLOR_RESET;
   logic [5:0]            scroll_rows = SCROLL_LINES_RESET;
   logic [7:0]            font_img [FONT_DEPTH];

   draw_op_type           item_draw_ops [$];   // ops of the command being modeled
   draw_op_type           draw_ops_due [$];    // ops still to come out, oldest first
   int                    mismatches = 0;

   always #1 clock = ~clock;

   text_console_glyph_renderer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ---------------------------------------------------------------------------
   // Console model
   // ---------------------------------------------------------------------------
   function automatic void put_op(logic [2:0] kind, int px, int py, logic [7:0] bits,
                                  logic [31:0] paint, logic [31:0] back);
      draw_op_type op;
      op.kind   = kind;
      op.px     = 10'(px);
      op.py     = 10'(py);
      op.bits   = bits;
      op.paint  = paint;
      op.back   = back;
      op.offset = '0;
      op.last   = 1'b0;
      item_draw_ops.push_back(op);
   endfunction

   // cursor outline: solid top and bottom rows, sides in between
   function automatic void draw_box(logic [31:0] color);
      for (int j = 0; j < GLYPH_HEIGHT; j++)
         put_op(KIND_MASK, txt_col * 8, txt_row * GLYPH_HEIGHT + j,
                (j == 0 || j == GLYPH_HEIGHT - 1) ? BOX_EDGE : BOX_SIDE,
                txt_hidden ? 32'h0 : color, 32'h0);
   endfunction

   function automatic void draw_glyph(logic [7:0] code, logic [31:0] fg, logic [31:0] bg);
      for (int j = 0; j < GLYPH_HEIGHT; j++)
         put_op(KIND_GLYPH, txt_col * 8, txt_row * GLYPH_HEIGHT + j,
                font_img[int'(code) * 16 + j], fg, bg);
   endfunction

   function automatic void print_char(req_data_type d);
      int k;
      if (d.x_valid) txt_col = (d.x_override > COLUMNS - 1) ? COLUMNS - 1 : d.x_override;
      if (d.y_valid) txt_row = (d.y_override > ROWS - 1) ? ROWS - 1 : d.y_override;
      case (d.char_code)
         CH_NEWLINE: begin
            txt_col = 0;
            txt_row++;
         end
         CH_RETURN: txt_col = 0;
         CH_BACKSPACE: begin
            // erase the box, step back, blank the cell
            draw_box(32'h0);
            if (txt_col > 0) txt_col--;
            draw_glyph(CH_SPACE, d.fg_color, d.glyph_bg);
         end
         default: begin
            draw_glyph(d.char_code, d.fg_color, d.glyph_bg);
            txt_col++;
         end
      endcase
      if (txt_col >= COLUMNS) begin
         txt_col = 0;
         txt_row++;
      end
      if (txt_row >= ROWS) begin
         // zero lines acts as one, more than the screen as the whole screen
         k = scroll_rows;
         if (k < 1) k = 1;
         if (k > ROWS) k = ROWS;
         put_op(KIND_SCROLL, 0, k * GLYPH_HEIGHT, 8'(k), 32'h0, 32'h0);
         txt_row = (txt_row >= k) ? txt_row - k : 0;
         if (txt_row > ROWS - 1) txt_row = ROWS - 1;
         txt_col = 0;
      end
   endfunction

   // fills item_draw_ops with what one accepted command draws
   function automatic void predict_draw_ops(logic [2:0] cmd, req_data_type d);
      int slot;
      int ofs;
      item_draw_ops.delete();
      case (cmd)
         CMD_PRINT: print_char(d);
         CMD_ERASE: draw_box(32'h0);
         CMD_DRAW:  draw_box(box_color);
         CMD_OFFSET: begin
            slot = int'(d.cursor_offset) / 2;
            draw_box(32'h0);
            txt_row = (slot / COLUMNS > ROWS - 1) ? ROWS - 1 : slot / COLUMNS;
            txt_col = slot % COLUMNS;
            draw_box(box_color);
         end
         CMD_HIDDEN: begin
            txt_hidden = d.hide_cursor;
            draw_box(box_color);
         end
         CMD_CLEAR: begin
            txt_col = 0;
            txt_row = 0;
            put_op(KIND_CLEAR, 0, 0, 8'h00, 32'h0, 32'h0);
         end
         CMD_LOAD: font_img[d.font_address] = d.font_bits;
         default: ;
      endcase
      if (item_draw_ops.size() == 0) put_op(KIND_NONE, 0, 0, 8'h00, 32'h0, 32'h0);
      ofs = (txt_row * COLUMNS + txt_col) * 2;
      foreach (item_draw_ops[i]) begin
         item_draw_ops[i].offset = 14'(ofs);
         item_draw_ops[i].last   = (i == item_draw_ops.size() - 1);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   // Valid is left high after a transfer; the next call either drives the
   // next command in the same step or drops valid while it idles, so valid
   // never sees two assignments in one step.
   task automatic send_cmd(logic [2:0] cmd, req_data_type d, logic typed,
                           logic [2:0] want_kind, logic [13:0] want_ofs);
      draw_op_type fixed;
      while (!steady_run && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      predict_draw_ops(cmd, d);
      if (typed) begin
         fixed        = '0;
         fixed.kind   = want_kind;
         fixed.offset = want_ofs;
         fixed.last   = 1'b1;
         draw_ops_due.push_back(fixed);
      end else begin
         foreach (item_draw_ops[i]) draw_ops_due.push_back(item_draw_ops[i]);
      end
   endtask

   // drop valid right after the last transfer and wait for the console to go quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      while (draw_ops_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // both registers back to back; only called with the block quiet
   task automatic set_registers(logic [31:0] color, logic [5:0] lines);
      csr_valid <= 1'b1;
      csr_index <= REG_CARET_COLOR;
      csr_data  <= color;
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_SCROLL_LINES;
      csr_data  <= {26'd0, lines};
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      box_color   = color;
      scroll_rows = lines;
   endtask

   // Mostly prints, with enough newlines, row overrides past the bottom and
   // large offsets that wraps and scrolls come up often. Printed glyphs and
   // font rewrites stay within the loaded glyph set.
   function automatic void pick_random(output logic [2:0] cmd, output req_data_type d);
      int roll;
      d = req_data_type'({$urandom, $urandom, $urandom, $urandom});
      d.pad          = '0;
      d.x_valid      = ($urandom_range(3) == 0);
      d.y_valid      = ($urandom_range(4) == 0);
      d.char_code    = GLYPH_SET[$urandom_range(4)];
      d.font_address = {GLYPH_SET[$urandom_range(4)], 4'($urandom_range(15))};
      roll = $urandom_range(99);
      if (roll < 12)      d.char_code = CH_NEWLINE;
      else if (roll < 17) d.char_code = CH_RETURN;
      else if (roll < 25) d.char_code = CH_BACKSPACE;
      roll = $urandom_range(99);
      if (roll < 68)      cmd = CMD_PRINT;
      else if (roll < 72) cmd = CMD_ERASE;
      else if (roll < 77) cmd = CMD_DRAW;
      else if (roll < 84) cmd = CMD_OFFSET;
      else if (roll < 88) cmd = CMD_HIDDEN;
      else if (roll < 91) cmd = CMD_CLEAR;
      else if (roll < 97) cmd = CMD_LOAD;
      else                cmd = CMD_NOP;
   endfunction

   initial begin
      logic [2:0]   cmd;
      req_data_type d;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Every glyph the bench prints is loaded first, so no glyph row is
      // read before it is written.
      foreach (GLYPH_SET[g]) begin
         for (int r = 0; r < GLYPH_HEIGHT; r++) begin
            d = req_data_type'({$urandom, $urandom, $urandom, $urandom});
            d.pad          = '0;
            d.font_address = {GLYPH_SET[g], 4'(r)};
            send_cmd(CMD_LOAD, d, 1'b0, KIND_NONE, '0);
         end
      end

      // Directed table at the reset register values.
      foreach (DIRECTED[i]) begin
         d               = '0;
         d.char_code     = DIRECTED[i].ch;
         d.x_valid       = DIRECTED[i].xv;
         d.x_override    = DIRECTED[i].x;
         d.y_valid       = DIRECTED[i].yv;
         d.y_override    = DIRECTED[i].y;
         d.fg_color      = DIRECTED[i].fg;
         d.glyph_bg      = DIRECTED[i].bg;
         d.cursor_offset = DIRECTED[i].ofs;
         d.hide_cursor   = DIRECTED[i].hide;
         d.font_address  = DIRECTED[i].addr;
         d.font_bits     = DIRECTED[i].bits;
         send_cmd(DIRECTED[i].cmd, d, DIRECTED[i].typed, DIRECTED[i].want_kind,
                  DIRECTED[i].want_ofs);
      end

      // Random phases, each under its own register setting. Phase 1 runs
      // with both sides always ready; phase 2 holds the sender off halfway.
      for (int p = 0; p < 4; p++) begin
         drain();
         set_registers((p == 1) ? 32'hFFFFFFFF : (p == 2) ? 32'h0 : $urandom,
                       SCROLL_PLAN[p]);
         steady_run <= (p == 1);
         for (int n = 0; n < 36; n++) begin
            if (p == 2 && n == 18) drain();
            pick_random(cmd, d);
            send_cmd(cmd, d, 1'b0, KIND_NONE, '0);
         end
      end
      drain();

      // anything straggling in after the last expected op is a failure too
      repeat (40) @(posedge clock);
      if (draw_ops_due.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= steady_run || ($urandom_range(99) >= 37);
   end

   function automatic string fmt_op(draw_op_type op);
      return $sformatf("kind %0d x %0d y %0d bits %02h paint %08h back %08h ofs %0d last %0d",
                       op.kind, op.px, op.py, op.bits, op.paint, op.back, op.offset,
                       op.last);
   endfunction

   // every rsp_ transfer is checked against the oldest pending op
   always @(posedge clock) begin : check_ops
      rsp_data_type got;
      draw_op_type  seen;
      draw_op_type  want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got         = rsp_data_type'(rsp_tdata);
         seen.kind   = rsp_tuser;
         seen.px     = got.pixel_x;
         seen.py     = got.pixel_y;
         seen.bits   = got.row_bits;
         seen.paint  = got.paint_color;
         seen.back   = got.back_color;
         seen.offset = got.offset_now;
         seen.last   = rsp_tlast;
         if (draw_ops_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: op with nothing pending: %s", $time, fmt_op(seen));
         end else begin
            want = draw_ops_due.pop_front();
            if (seen.kind !== want.kind || seen.px !== want.px || seen.py !== want.py ||
                seen.bits !== want.bits || seen.paint !== want.paint ||
                seen.back !== want.back || seen.offset !== want.offset ||
                seen.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: op mismatch\n  exp %s\n  got %s", $time, fmt_op(want),
                           fmt_op(seen));
            end
         end
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2000000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

// File: text_console_glyph_renderer.f
+incdir+sv
sv/tcgr_pkg.sv
sv/tcgr_ram.sv
sv/tcgr_plan.sv
sv/tcgr_seq.sv
sv/tcgr_out.sv
sv/text_console_glyph_renderer.sv
sv/tcgr_port_check.sv
bench/tb_top.sv
